// ===== hdl/edf_pkg.sv =====
package edf_pkg;

	localparam int NUM_TASKS_DEF = 8;
	localparam int DL_W = 18;

	typedef logic signed [DL_W-1:0] dl_t;

	// lowest tick-relative deadline, missed deadlines stop falling here
	localparam dl_t DL_MIN = {1'b1, {(DL_W-1){1'b0}}};

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [15:0] burst;
		logic [15:0] rel_dl;
		logic [15:0] period;
		logic [15:0] rem;
		dl_t         dl_left;
		logic [15:0] countdown;
	} task_entry_t;

	typedef struct packed {
		logic in_ready;
		logic scan;
		logic finish;
	} ctrl_t;

endpackage

// ===== hdl/edf_periodic_task_scheduler.sv =====
// Earliest-deadline-first scheduler for up to NUM_TASKS periodic tasks. A beat
// with mode 0 loads one task entry (burst, relative deadline, period; period 0
// disables the task) and returns nothing; the task is released on the next
// tick. A beat with mode 1 is one scheduler tick and returns one result beat:
// tick index, whether a task ran, which slot, and a flag on the first idle
// tick. From acceptance to the result register, a tick passes each slot in
// turn through the shared release/deadline/compare unit, then a commit state
// that charges the winning task one tick of work. in_ready is low for that
// whole time, and the commit waits while an earlier result is still not
// taken. All task state is cleared by reset, so no clearing pass is needed.
module edf_periodic_task_scheduler
	import edf_pkg::*;
#(
	parameter int NUM_TASKS = NUM_TASKS_DEF,
	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [2:0]  task_slot,
	input  logic [15:0] burst_time,
	input  logic [15:0] relative_deadline,
	input  logic [15:0] task_period,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] tick_number,
	output logic        cpu_busy,
	output logic [2:0]  running_task,
	output logic        idle_began
);

	// task table, one entry per slot
	task_entry_t tab_q [NUM_TASKS];

	ctrl_t            ctrl;
	logic [IDX_W-1:0] idx;
	logic             out_free;
	logic             in_beat;
	logic             load_beat;
	logic             tick_beat;

	// slot decode, load beats beyond the task count are dropped
	logic [IDX_W+2:0] slot_ext;
	logic [IDX_W-1:0] slot_idx;
	logic             slot_ok;

	// shared unit
	task_entry_t ent;
	task_entry_t upd;
	logic        take;

	// running best of the current scan
	logic             found_q;
	dl_t              best_q;
	logic [IDX_W-1:0] chosen_q;
	logic [15:0]      rem_best_q;
	logic [IDX_W+2:0] chosen_ext;

	logic [31:0] tick_q;
	logic        was_idle_q;

	// result register
	logic        out_valid_q;
	logic [31:0] tick_number_q;
	logic        cpu_busy_q;
	logic [2:0]  running_task_q;
	logic        idle_began_q;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = ctrl.in_ready;
	assign in_beat   = in_valid && ctrl.in_ready;
	assign load_beat = in_beat && (mode == MODE_LOAD);
	assign tick_beat = in_beat && (mode == MODE_TICK);

	assign slot_ext = (IDX_W + 3)'(task_slot);
	assign slot_idx = slot_ext[IDX_W-1:0];
	assign slot_ok  = ({2'b00, task_slot} < 5'(NUM_TASKS));

	assign chosen_ext = (IDX_W + 3)'(chosen_q);

	edf_ctrl #(
		.NUM_TASKS(NUM_TASKS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_mode (mode),
		.out_free(out_free),
		.ctrl    (ctrl),
		.idx     (idx)
	);

	assign ent = tab_q[idx];

	edf_scan_unit u_scan (
		.ent  (ent),
		.found(found_q),
		.best (best_q),
		.upd  (upd),
		.take (take)
	);

	// table: load, scan write-back and commit happen in different states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TASKS; k++) begin
				tab_q[k] <= '0;
			end
		end else begin
			priority if (load_beat && slot_ok) begin
				tab_q[slot_idx].burst     <= burst_time;
				tab_q[slot_idx].rel_dl    <= relative_deadline;
				tab_q[slot_idx].period    <= task_period;
				tab_q[slot_idx].rem       <= 16'd0;
				tab_q[slot_idx].dl_left   <= '0;
				tab_q[slot_idx].countdown <= 16'd0;
			end else if (ctrl.scan) begin
				tab_q[idx] <= upd;
			end else if (ctrl.finish && found_q) begin
				// winner's entry is not touched again after its scan slot
				tab_q[chosen_q].rem <= rem_best_q - 16'd1;
			end
		end
	end

	// running minimum over the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (tick_beat) begin
			found_q <= 1'b0;
		end else if (ctrl.scan && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan && take) begin
			best_q     <= upd.dl_left;
			chosen_q   <= idx;
			rem_best_q <= upd.rem;
		end
	end

	// tick count and idle tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= 32'd0;
			was_idle_q <= 1'b0;
		end else if (ctrl.finish) begin
			tick_q     <= tick_q + 32'd1;
			was_idle_q <= !found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			tick_number_q  <= tick_q;
			cpu_busy_q     <= found_q;
			running_task_q <= found_q ? chosen_ext[2:0] : 3'd0;
			idle_began_q   <= !found_q && !was_idle_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign tick_number  = tick_number_q;
	assign cpu_busy     = cpu_busy_q;
	assign running_task = running_task_q;
	assign idle_began   = idle_began_q;

`ifndef SYNTHESIS
	// no input beat is taken while a tick is being worked on
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.scan || ctrl.finish) |-> !in_ready)
		else $error("input ready during tick processing");

	// a commit always lands a result beat
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |=> out_valid)
		else $error("commit without result beat");

	// each commit advances the tick count by exactly one
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |=> (tick_q == $past(tick_q) + 32'd1))
		else $error("tick count did not step");

	// idle results carry slot zero and no busy flag with the idle flag
	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cpu_busy |-> (running_task == 3'd0))
		else $error("idle result with nonzero slot");

	a_idle_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle_began |-> !cpu_busy)
		else $error("idle flag on a busy tick");
`endif

endmodule

// ===== hdl/edf_scan_unit.sv =====
module edf_scan_unit
	import edf_pkg::*;
(
	input  task_entry_t ent,
	input  logic        found,
	input  dl_t         best,
	output task_entry_t upd,
	output logic        take
);

	logic release_now;

	always_comb begin
		release_now = (ent.period != 16'd0) && (ent.countdown == 16'd0);
		upd = ent;
		if (release_now) begin
			upd.rem       = ent.burst;
			upd.dl_left   = dl_t'({2'b00, ent.rel_dl});
			upd.countdown = ent.period - 16'd1;
		end else begin
			// saturate at the floor
			if (ent.dl_left != DL_MIN) begin
				upd.dl_left = ent.dl_left - dl_t'(1);
			end
			if ((ent.period != 16'd0) && (ent.countdown != 16'd0)) begin
				upd.countdown = ent.countdown - 16'd1;
			end
		end
		// strict less keeps the lowest slot on ties
		take = (upd.rem != 16'd0) && (!found || ($signed(upd.dl_left) < $signed(best)));
	end

endmodule

// ===== hdl/edf_ctrl.sv =====
module edf_ctrl
	import edf_pkg::*;
#(
	parameter int NUM_TASKS = NUM_TASKS_DEF,
	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_mode,
	input  logic             out_free,
	output ctrl_t            ctrl,
	output logic [IDX_W-1:0] idx
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             last;

	assign last = (idx_q == IDX_W'(NUM_TASKS - 1));
	assign idx  = idx_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (in_mode == MODE_TICK)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.in_ready = (state_q == ST_IDLE);
		ctrl.scan     = (state_q == ST_SCAN);
		ctrl.finish   = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.scan) begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

endmodule
